// ===== rtl/bmas_pkg.sv =====
// Shared constants, opcodes and the memory request type for the byte memory access slave.
// Used by bmas_byte_store and byte_memory_access_slave_top; depends on nothing else.
package bmas_pkg;

    localparam int MEM_ADDR_BITS = 16;
    localparam int ECHO_DEPTH    = 256;
    localparam int ECHO_BITS     = (ECHO_DEPTH > 1) ? $clog2(ECHO_DEPTH) : 1;

    localparam logic [8:0] HDR_LEN = 9'd6;
    localparam logic [8:0] POS_MAX = 9'd511;

    localparam logic [3:0] OP_READ = 4'h0;
    localparam logic [3:0] OP_SET  = 4'h1;
    localparam logic [3:0] OP_AND  = 4'h3;
    localparam logic [3:0] OP_OR   = 4'h5;
    localparam logic [3:0] OP_XOR  = 4'h7;

    typedef logic [MEM_ADDR_BITS-1:0] mem_addr_t;

    typedef struct packed {
        logic      rd_en;
        mem_addr_t rd_addr;
        logic      wr_en;
        mem_addr_t wr_addr;
        logic [7:0] wr_data;
    } mem_req_t;

endpackage

// ===== rtl/byte_memory_access_slave_top.sv =====
// Byte memory access slave: request frame parsing, read-modify-write of the byte store,
// echo store and CRC-16 response generation. Depends on bmas_pkg and bmas_byte_store.
// Throughput: one transfer per cycle on the input; a pulled response byte passes the
// stage after the memory read and then the output register.
// The input stalls only while a pulled byte waits behind an output byte not yet taken.
// Reset: control state clears at once; the byte store is then swept to zero over all
// 2^MEM_ADDR_BITS (65536) addresses, during which in_ready stays low.
module byte_memory_access_slave_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] rx_byte,
    input  logic       frame_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] tx_byte,
    output logic       tx_last
);
    import bmas_pkg::*;

    localparam logic [2:0] K_RMW   = 3'd0;
    localparam logic [2:0] K_HDR   = 3'd1;
    localparam logic [2:0] K_MEM   = 3'd2;
    localparam logic [2:0] K_ECHO  = 3'd3;
    localparam logic [2:0] K_CRCLO = 3'd4;
    localparam logic [2:0] K_CRCHI = 3'd5;

    function automatic logic is_write_op(input logic [3:0] op);
        return (op == OP_SET) || (op == OP_AND) || (op == OP_OR) || (op == OP_XOR);
    endfunction

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [ECHO_BITS-1:0] echo_inc(input logic [ECHO_BITS-1:0] pos);
        return (pos == ECHO_BITS'(ECHO_DEPTH - 1)) ? '0 : pos + 1'b1;
    endfunction

    // Frame and response state.
    logic [7:0]  unit_id_reg, unit_id_next;
    logic [7:0]  func_code_reg, func_code_next;
    logic [7:0]  sub_op_reg, sub_op_next;
    logic [15:0] start_addr_reg, start_addr_next;
    logic [7:0]  data_count_reg, data_count_next;
    logic [8:0]  rx_pos_reg, rx_pos_next;
    logic [8:0]  tx_pos_reg, tx_pos_next;
    logic [8:0]  tx_total_reg, tx_total_next;
    logic [15:0] crc_reg, crc_next;
    logic [ECHO_BITS-1:0] echo_wpos_reg, echo_wpos_next;
    logic [ECHO_BITS-1:0] echo_rpos_reg, echo_rpos_next;

    // Stage after the memory read.
    logic        s1_valid_reg, s1_valid_next;
    logic [2:0]  s1_kind_reg, s1_kind_next;
    logic [3:0]  s1_op_reg, s1_op_next;
    logic [7:0]  s1_byte_reg, s1_byte_next;
    mem_addr_t   s1_addr_reg, s1_addr_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        tx_last_reg, tx_last_next;

    logic [7:0]  echo_mem [0:ECHO_DEPTH-1];
    logic [7:0]  echo_rdata_reg;

    mem_req_t    mreq;
    logic [7:0]  mem_rdata;
    logic        mem_busy;

    logic        accept, req, pull, s1_go;
    logic [3:0]  op_cur, op_new;
    logic [8:0]  data_idx;
    logic        in_data;
    logic [9:0]  cnt;
    logic        pend;
    logic [9:0]  tp2, tot10;
    logic [8:0]  body_off;
    logic        echo_rd;
    logic [7:0]  s1_val, rmw_val;

    bmas_byte_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mreq),
        .rd_data (mem_rdata),
        .busy    (mem_busy)
    );

    assign s1_go    = s1_valid_reg && ((s1_kind_reg == K_RMW) || !out_valid_reg || out_ready);
    assign in_ready = !mem_busy && (!s1_valid_reg || s1_go);
    assign accept   = in_valid && in_ready;
    assign req      = accept && !cmd;
    assign pull     = accept && cmd;

    assign op_cur   = sub_op_reg[3:0];
    assign data_idx = rx_pos_reg - HDR_LEN;
    assign in_data  = (rx_pos_reg >= HDR_LEN) && (data_idx < {1'b0, data_count_reg})
                      && is_write_op(op_cur);
    assign cnt      = {1'b0, rx_pos_reg} + 10'd1;
    assign pend     = (tx_total_reg != 9'd0) && (tx_pos_reg < tx_total_reg);
    assign tp2      = {1'b0, tx_pos_reg} + 10'd2;
    assign tot10    = {1'b0, tx_total_reg};
    assign body_off = tx_pos_reg - 9'd4;

    always_comb
    begin
        unique case (s1_op_reg)
            OP_SET:  rmw_val = s1_byte_reg;
            OP_AND:  rmw_val = mem_rdata & s1_byte_reg;
            OP_OR:   rmw_val = mem_rdata | s1_byte_reg;
            default: rmw_val = mem_rdata ^ s1_byte_reg;
        endcase
        unique case (s1_kind_reg)
            K_MEM:   s1_val = mem_rdata;
            K_ECHO:  s1_val = echo_rdata_reg;
            K_CRCLO: s1_val = crc_reg[7:0];
            K_CRCHI: s1_val = crc_reg[15:8];
            default: s1_val = s1_byte_reg;
        endcase
    end

    always_comb
    begin
        unit_id_next    = unit_id_reg;
        func_code_next  = func_code_reg;
        sub_op_next     = sub_op_reg;
        start_addr_next = start_addr_reg;
        data_count_next = data_count_reg;
        rx_pos_next     = rx_pos_reg;
        tx_pos_next     = tx_pos_reg;
        tx_total_next   = tx_total_reg;
        crc_next        = crc_reg;
        echo_wpos_next  = echo_wpos_reg;
        echo_rpos_next  = echo_rpos_reg;
        s1_valid_next   = s1_valid_reg;
        s1_kind_next    = s1_kind_reg;
        s1_op_next      = s1_op_reg;
        s1_byte_next    = s1_byte_reg;
        s1_addr_next    = s1_addr_reg;
        out_valid_next  = out_valid_reg;
        tx_byte_next    = tx_byte_reg;
        tx_last_next    = tx_last_reg;
        op_new          = op_cur;
        echo_rd         = 1'b0;
        mreq            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Finish the item held after the memory read.
        if (s1_go)
        begin
            s1_valid_next = 1'b0;
            if (s1_kind_reg == K_RMW)
            begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = s1_addr_reg;
                mreq.wr_data = rmw_val;
            end
            else
            begin
                out_valid_next = 1'b1;
                tx_byte_next   = s1_val;
                tx_last_next   = (s1_kind_reg == K_CRCHI);
                if ((s1_kind_reg == K_HDR) || (s1_kind_reg == K_MEM) || (s1_kind_reg == K_ECHO))
                begin
                    crc_next = crc_feed(crc_reg, s1_val);
                end
            end
        end

        if (req)
        begin
            tx_total_next = 9'd0;
            unique case (rx_pos_reg)
                9'd0: unit_id_next   = rx_byte;
                9'd1: func_code_next = rx_byte;
                9'd2: sub_op_next    = rx_byte;
                9'd3: start_addr_next = {rx_byte, start_addr_reg[7:0]};
                9'd4: start_addr_next = {start_addr_reg[15:8], rx_byte};
                9'd5:
                begin
                    data_count_next = rx_byte;
                    echo_wpos_next  = '0;
                end
                default:
                begin
                    if (in_data)
                    begin
                        mreq.rd_en     = 1'b1;
                        mreq.rd_addr   = MEM_ADDR_BITS'(start_addr_reg + {7'd0, data_idx});
                        s1_valid_next  = 1'b1;
                        s1_kind_next   = K_RMW;
                        s1_op_next     = op_cur;
                        s1_byte_next   = rx_byte;
                        s1_addr_next   = mreq.rd_addr;
                        echo_wpos_next = echo_inc(echo_wpos_reg);
                    end
                end
            endcase
            if (frame_end)
            begin
                op_new = sub_op_next[3:0];
                if (cnt >= 10'd6)
                begin
                    if (op_new == OP_READ)
                    begin
                        tx_total_next = {1'b0, data_count_next} + 9'd6;
                    end
                    else if (is_write_op(op_new) && ((cnt - 10'd6) >= {2'b00, data_count_next}))
                    begin
                        tx_total_next = {1'b0, data_count_next} + 9'd8;
                    end
                end
                tx_pos_next    = 9'd0;
                crc_next       = 16'hFFFF;
                rx_pos_next    = 9'd0;
                echo_rpos_next = '0;
            end
            else if (rx_pos_reg < POS_MAX)
            begin
                rx_pos_next = rx_pos_reg + 9'd1;
            end
        end
        else if (pull)
        begin
            if (!pend)
            begin
                tx_total_next = 9'd0;
            end
            else
            begin
                s1_valid_next = 1'b1;
                if (tp2 < tot10)
                begin
                    s1_kind_next = K_HDR;
                    priority if (tx_pos_reg == 9'd0)
                        s1_byte_next = unit_id_reg;
                    else if (tx_pos_reg == 9'd1)
                        s1_byte_next = func_code_reg;
                    else if (tx_pos_reg == 9'd2)
                        s1_byte_next = sub_op_reg;
                    else if (op_cur == OP_READ)
                    begin
                        if (tx_pos_reg == 9'd3)
                            s1_byte_next = data_count_reg;
                        else
                        begin
                            s1_kind_next  = K_MEM;
                            mreq.rd_en    = 1'b1;
                            mreq.rd_addr  = MEM_ADDR_BITS'(start_addr_reg + {7'd0, body_off});
                        end
                    end
                    else if (tx_pos_reg == 9'd3)
                        s1_byte_next = start_addr_reg[15:8];
                    else if (tx_pos_reg == 9'd4)
                        s1_byte_next = start_addr_reg[7:0];
                    else if (tx_pos_reg == 9'd5)
                        s1_byte_next = data_count_reg;
                    else
                    begin
                        s1_kind_next   = K_ECHO;
                        echo_rd        = 1'b1;
                        echo_rpos_next = echo_inc(echo_rpos_reg);
                    end
                    tx_pos_next = tx_pos_reg + 9'd1;
                end
                else if (tp2 == tot10)
                begin
                    s1_kind_next = K_CRCLO;
                    tx_pos_next  = tx_pos_reg + 9'd1;
                end
                else
                begin
                    s1_kind_next  = K_CRCHI;
                    tx_total_next = 9'd0;
                    tx_pos_next   = 9'd0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req && in_data)
        begin
            echo_mem[echo_wpos_reg] <= rx_byte;
        end
        if (echo_rd)
        begin
            echo_rdata_reg <= echo_mem[echo_rpos_reg];
        end
        s1_kind_reg <= s1_kind_next;
        s1_op_reg   <= s1_op_next;
        s1_byte_reg <= s1_byte_next;
        s1_addr_reg <= s1_addr_next;
        tx_byte_reg <= tx_byte_next;
        tx_last_reg <= tx_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_id_reg    <= 8'h00;
            func_code_reg  <= 8'h00;
            sub_op_reg     <= 8'h00;
            start_addr_reg <= 16'h0000;
            data_count_reg <= 8'h00;
            rx_pos_reg     <= 9'd0;
            tx_pos_reg     <= 9'd0;
            tx_total_reg   <= 9'd0;
            crc_reg        <= 16'hFFFF;
            echo_wpos_reg  <= '0;
            echo_rpos_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            unit_id_reg    <= unit_id_next;
            func_code_reg  <= func_code_next;
            sub_op_reg     <= sub_op_next;
            start_addr_reg <= start_addr_next;
            data_count_reg <= data_count_next;
            rx_pos_reg     <= rx_pos_next;
            tx_pos_reg     <= tx_pos_next;
            tx_total_reg   <= tx_total_next;
            crc_reg        <= crc_next;
            echo_wpos_reg  <= echo_wpos_next;
            echo_rpos_reg  <= echo_rpos_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign tx_last   = tx_last_reg;

endmodule

// ===== rtl/bmas_byte_store.sv =====
// Byte store: synchronous memory with a clearing sweep after reset and
// forwarding of the most recent write. Depends on bmas_pkg.
module bmas_byte_store (
    input  logic              clk,
    input  logic              rst_n,
    input  bmas_pkg::mem_req_t req,
    output logic [7:0]        rd_data,
    output logic              busy
);
    import bmas_pkg::*;

    logic [7:0] mem [0:(1 << MEM_ADDR_BITS)-1];
    logic [7:0] rdata_reg;
    mem_addr_t  rd_addr_reg;
    mem_addr_t  clr_addr_reg;
    logic       busy_reg;
    mem_addr_t  lw_addr_reg;
    logic [7:0] lw_data_reg;
    logic       lw_valid_reg;

    logic       we;
    mem_addr_t  waddr;
    logic [7:0] wdata;

    always_comb
    begin
        if (busy_reg)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
            wdata = 8'h00;
        end
        else
        begin
            we    = req.wr_en;
            waddr = req.wr_addr;
            wdata = req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg   <= mem[req.rd_addr];
            rd_addr_reg <= req.rd_addr;
        end
    end

    // The sweep walks every address once, writing zero, before any transfer is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
            lw_valid_reg <= 1'b0;
            lw_addr_reg  <= '0;
            lw_data_reg  <= 8'h00;
        end
        else
        begin
            if (busy_reg)
            begin
                if (clr_addr_reg == {MEM_ADDR_BITS{1'b1}})
                begin
                    busy_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (we)
            begin
                lw_valid_reg <= 1'b1;
                lw_addr_reg  <= waddr;
                lw_data_reg  <= wdata;
            end
        end
    end

    // A write landing on the same edge as the read is not seen by the array read, so
    // the last write to an address always stands for its current content.
    assign rd_data = (lw_valid_reg && (lw_addr_reg == rd_addr_reg)) ? lw_data_reg : rdata_reg;
    assign busy    = busy_reg;

endmodule
